/* design/tilp_pkg.sv */
// Shared types and constants for the traffic line parser.
`default_nettype none

package tilp_pkg;

    // Queue depth between the byte classifier and the parser.
    localparam int FIFO_DEPTH = 4;

    // Longest address text, in bytes, accepted before the first tab.
    localparam int MAX_ADDR_TEXT = 16;

    // Megabytes to bytes: times 1048576.
    localparam int TRAFFIC_SHIFT = 20;

    typedef enum logic [2:0] {
        CH_DIGIT,
        CH_TAB,
        CH_DOT,
        CH_SPACE,
        CH_PLUS,
        CH_MINUS,
        CH_OTHER,
        CH_END
    } char_class_t;

    // One classified byte, as queued between the front and the back.
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
    } tok_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_SKIP1,
        PH_TRAFFIC,
        PH_SKIP2,
        PH_COUNT,
        PH_FAIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_ADDR    = 3'd1,
        ST_NO_TAB      = 3'd2,
        ST_BAD_TRAFFIC = 3'd3,
        ST_BAD_COUNT   = 3'd4
    } status_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic lead;
        logic stop;
    } num_flags_t;

endpackage

`default_nettype wire

/* design/tilp_front.sv */
// Front end: takes bytes, drops text after a zero byte, classifies and queues.
`default_nettype none

module tilp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          text_byte,
    input  wire logic                line_end,
    input  wire tilp_pkg::fifo_stat_t fifo_stat,
    output logic                     push,
    output tilp_pkg::tok_t           push_tok
);

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_DOT   = 8'h2E;

    logic accept;
    logic stopped_reg;
    logic stopped_next;
    tilp_pkg::char_class_t cls;

    assign in_stall = fifo_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (text_byte inside {[8'h30:8'h39]})
        begin
            cls = tilp_pkg::CH_DIGIT;
        end
        else if (text_byte == CHR_TAB)
        begin
            cls = tilp_pkg::CH_TAB;
        end
        else if (text_byte == CHR_DOT)
        begin
            cls = tilp_pkg::CH_DOT;
        end
        else if (text_byte == CHR_SPACE || (text_byte inside {[8'h0A:8'h0D]}))
        begin
            cls = tilp_pkg::CH_SPACE;
        end
        else if (text_byte == CHR_PLUS)
        begin
            cls = tilp_pkg::CH_PLUS;
        end
        else if (text_byte == CHR_MINUS)
        begin
            cls = tilp_pkg::CH_MINUS;
        end
        else
        begin
            cls = tilp_pkg::CH_OTHER;
        end
    end

    // Zero byte ends the text; it and the rest to the terminator are dropped.
    always_comb
    begin
        stopped_next = stopped_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (line_end)
            begin
                stopped_next = 1'b0;
                push         = 1'b1;
            end
            else if (!stopped_reg)
            begin
                if (text_byte == 8'h00)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                end
            end
        end
    end

    assign push_tok.cls   = line_end ? tilp_pkg::CH_END : cls;
    assign push_tok.digit = text_byte[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else
        begin
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

/* design/tilp_fifo.sv */
// Short flop-based queue of classified bytes.
`default_nettype none

module tilp_fifo #(
    parameter int DEPTH = tilp_pkg::FIFO_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire tilp_pkg::tok_t       push_tok,
    input  wire logic                 pop,
    output tilp_pkg::tok_t            head,
    output tilp_pkg::fifo_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tilp_pkg::tok_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/tilp_back.sv */
// Back end: line parser state machine, number accumulation and result register.
`default_nettype none

module tilp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tilp_pkg::tok_t       head,
    input  wire tilp_pkg::fifo_stat_t fifo_stat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                status,
    output logic [31:0]               address,
    output logic [63:0]               traffic_bytes,
    output logic [63:0]               record_count
);

    localparam int KEEP_W = 64 - tilp_pkg::TRAFFIC_SHIFT;

    // parser state
    tilp_pkg::phase_t     phase_reg, phase_next;
    logic [8:0]           octet_value_reg, octet_value_next;
    logic [1:0]           octet_digits_reg, octet_digits_next;
    logic [2:0]           octet_index_reg, octet_index_next;
    logic [31:0]          address_shift_reg, address_shift_next;
    logic [5:0]           field_length_reg, field_length_next;
    logic [63:0]          acc_reg, acc_next;
    tilp_pkg::num_flags_t flags_reg, flags_next;
    logic [63:0]          traffic_hold_reg, traffic_hold_next;
    tilp_pkg::status_t    error_code_reg, error_code_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    tilp_pkg::status_t    out_status_reg, out_status_next;
    logic [31:0]          out_address_reg, out_address_next;
    logic [63:0]          out_traffic_reg, out_traffic_next;
    logic [63:0]          out_count_reg, out_count_next;

    logic                 is_end;
    logic                 is_tab;
    logic                 take;
    logic                 load;

    logic [67:0]          num_prod;
    logic [63:0]          num_acc_step;
    tilp_pkg::num_flags_t num_flags_step;

    logic [11:0]          octet_new;
    logic                 addr_bad;
    logic                 traffic_bad;
    logic [KEEP_W-1:0]    traffic_keep;
    logic [63:0]          number_value;
    tilp_pkg::status_t    end_status;

    assign is_end = (head.cls == tilp_pkg::CH_END);
    assign is_tab = (head.cls == tilp_pkg::CH_TAB);
    // A terminator needs the result slot free; every other byte just goes.
    assign take   = !fifo_stat.empty && (!is_end || !out_valid_reg || !out_stall);
    assign load   = take && is_end;
    assign pop    = take;

    // strtoull-style digit step: acc*10 + d, overflow when it leaves 64 bits
    assign num_prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 68'(head.digit);

    always_comb
    begin
        num_acc_step   = acc_reg;
        num_flags_step = flags_reg;
        if (!flags_reg.stop)
        begin
            case (head.cls)
                tilp_pkg::CH_DIGIT:
                begin
                    num_flags_step.lead = 1'b1;
                    if (!flags_reg.ovf)
                    begin
                        if (num_prod[67:64] != 4'd0)
                        begin
                            num_flags_step.ovf = 1'b1;
                        end
                        else
                        begin
                            num_acc_step = num_prod[63:0];
                        end
                    end
                end
                // tab is white space too once inside the count field
                tilp_pkg::CH_SPACE, tilp_pkg::CH_TAB:
                begin
                    if (flags_reg.lead)
                    begin
                        num_flags_step.stop = 1'b1;
                    end
                end
                tilp_pkg::CH_PLUS, tilp_pkg::CH_MINUS:
                begin
                    if (flags_reg.lead)
                    begin
                        num_flags_step.stop = 1'b1;
                    end
                    else
                    begin
                        num_flags_step.lead = 1'b1;
                        num_flags_step.neg  = (head.cls == tilp_pkg::CH_MINUS);
                    end
                end
                default:
                begin
                    num_flags_step.stop = 1'b1;
                end
            endcase
        end
    end

    assign octet_new = ({3'b0, octet_value_reg} << 3) + ({3'b0, octet_value_reg} << 1)
                       + 12'(head.digit);

    assign addr_bad = (error_code_reg != tilp_pkg::ST_OK) || (octet_index_reg != 3'd4)
                      || (octet_digits_reg == 2'd0)
                      || (field_length_reg > 6'(tilp_pkg::MAX_ADDR_TEXT));

    // value all ones: either -1 or a plain 2^64-1
    assign traffic_bad = flags_reg.ovf
                         || (flags_reg.neg ? (acc_reg == 64'd1) : (&acc_reg));
    assign traffic_keep = flags_reg.neg ? (KEEP_W'(0) - acc_reg[KEEP_W-1:0])
                                        : acc_reg[KEEP_W-1:0];
    assign number_value = flags_reg.neg ? (64'd0 - acc_reg) : acc_reg;

    always_comb
    begin
        case (phase_reg)
            tilp_pkg::PH_SKIP2:
            begin
                end_status = tilp_pkg::ST_OK;
            end
            tilp_pkg::PH_COUNT:
            begin
                end_status = flags_reg.ovf ? tilp_pkg::ST_BAD_COUNT : tilp_pkg::ST_OK;
            end
            tilp_pkg::PH_FAIL:
            begin
                end_status = (error_code_reg == tilp_pkg::ST_OK) ? tilp_pkg::ST_BAD_ADDR
                                                                 : error_code_reg;
            end
            default:
            begin
                end_status = tilp_pkg::ST_NO_TAB;
            end
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            if (is_end)
            begin
                phase_next = tilp_pkg::PH_ADDR;
            end
            else
            begin
                case (phase_reg)
                    tilp_pkg::PH_ADDR:
                    begin
                        if (is_tab)
                        begin
                            phase_next = addr_bad ? tilp_pkg::PH_FAIL : tilp_pkg::PH_SKIP1;
                        end
                    end
                    tilp_pkg::PH_SKIP1:
                    begin
                        if (!is_tab)
                        begin
                            phase_next = tilp_pkg::PH_TRAFFIC;
                        end
                    end
                    tilp_pkg::PH_TRAFFIC:
                    begin
                        if (is_tab)
                        begin
                            phase_next = traffic_bad ? tilp_pkg::PH_FAIL : tilp_pkg::PH_SKIP2;
                        end
                    end
                    tilp_pkg::PH_SKIP2:
                    begin
                        if (!is_tab)
                        begin
                            phase_next = tilp_pkg::PH_COUNT;
                        end
                    end
                    tilp_pkg::PH_COUNT, tilp_pkg::PH_FAIL:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = tilp_pkg::PH_FAIL;
                    end
                endcase
            end
        end
    end

    // datapath and outputs
    always_comb
    begin
        octet_value_next   = octet_value_reg;
        octet_digits_next  = octet_digits_reg;
        octet_index_next   = octet_index_reg;
        address_shift_next = address_shift_reg;
        field_length_next  = field_length_reg;
        acc_next           = acc_reg;
        flags_next         = flags_reg;
        traffic_hold_next  = traffic_hold_reg;
        error_code_next    = error_code_reg;

        out_valid_next   = load || (out_valid_reg && out_stall);
        out_status_next  = out_status_reg;
        out_address_next = out_address_reg;
        out_traffic_next = out_traffic_reg;
        out_count_next   = out_count_reg;

        if (take)
        begin
            if (is_end)
            begin
                out_status_next = end_status;
                if (end_status == tilp_pkg::ST_OK)
                begin
                    out_address_next = address_shift_reg;
                    out_traffic_next = traffic_hold_reg;
                    out_count_next   = number_value;
                end
                else
                begin
                    out_address_next = '0;
                    out_traffic_next = '0;
                    out_count_next   = '0;
                end
                octet_value_next   = '0;
                octet_digits_next  = '0;
                octet_index_next   = '0;
                address_shift_next = '0;
                field_length_next  = '0;
                acc_next           = '0;
                flags_next         = '0;
                traffic_hold_next  = '0;
                error_code_next    = tilp_pkg::ST_OK;
            end
            else
            begin
                case (phase_reg)
                    tilp_pkg::PH_ADDR:
                    begin
                        if (is_tab)
                        begin
                            if (addr_bad)
                            begin
                                error_code_next = tilp_pkg::ST_BAD_ADDR;
                            end
                            else
                            begin
                                address_shift_next = {address_shift_reg[23:0],
                                                      octet_value_reg[7:0]};
                            end
                        end
                        else
                        begin
                            if (field_length_reg != 6'h3F)
                            begin
                                field_length_next = field_length_reg + 1'b1;
                            end
                            if (error_code_reg == tilp_pkg::ST_OK)
                            begin
                                if (head.cls == tilp_pkg::CH_DIGIT)
                                begin
                                    // leading zero or value above 255
                                    if ((octet_digits_reg != 2'd0 && octet_value_reg == 9'd0)
                                        || octet_new > 12'd255)
                                    begin
                                        error_code_next = tilp_pkg::ST_BAD_ADDR;
                                    end
                                    else
                                    begin
                                        octet_value_next = octet_new[8:0];
                                        if (octet_digits_reg == 2'd0)
                                        begin
                                            if (octet_index_reg >= 3'd4)
                                            begin
                                                error_code_next = tilp_pkg::ST_BAD_ADDR;
                                            end
                                            else
                                            begin
                                                octet_index_next = octet_index_reg + 1'b1;
                                            end
                                        end
                                        if (octet_digits_reg != 2'd3
                                            && !(octet_digits_reg == 2'd0
                                                 && octet_index_reg >= 3'd4))
                                        begin
                                            octet_digits_next = octet_digits_reg + 1'b1;
                                        end
                                    end
                                end
                                else if (head.cls == tilp_pkg::CH_DOT
                                         && octet_digits_reg != 2'd0)
                                begin
                                    if (octet_index_reg >= 3'd4)
                                    begin
                                        error_code_next = tilp_pkg::ST_BAD_ADDR;
                                    end
                                    else
                                    begin
                                        address_shift_next = {address_shift_reg[23:0],
                                                              octet_value_reg[7:0]};
                                        octet_value_next   = '0;
                                        octet_digits_next  = '0;
                                    end
                                end
                                else
                                begin
                                    error_code_next = tilp_pkg::ST_BAD_ADDR;
                                end
                            end
                        end
                    end
                    tilp_pkg::PH_SKIP1, tilp_pkg::PH_TRAFFIC:
                    begin
                        if (!is_tab)
                        begin
                            acc_next   = num_acc_step;
                            flags_next = num_flags_step;
                        end
                        else if (phase_reg == tilp_pkg::PH_TRAFFIC)
                        begin
                            if (traffic_bad)
                            begin
                                error_code_next = tilp_pkg::ST_BAD_TRAFFIC;
                            end
                            else
                            begin
                                traffic_hold_next = {traffic_keep,
                                                     {tilp_pkg::TRAFFIC_SHIFT{1'b0}}};
                                acc_next          = '0;
                                flags_next        = '0;
                            end
                        end
                    end
                    tilp_pkg::PH_SKIP2, tilp_pkg::PH_COUNT:
                    begin
                        if (!is_tab || phase_reg == tilp_pkg::PH_COUNT)
                        begin
                            acc_next   = num_acc_step;
                            flags_next = num_flags_step;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= tilp_pkg::PH_ADDR;
            octet_value_reg   <= '0;
            octet_digits_reg  <= '0;
            octet_index_reg   <= '0;
            address_shift_reg <= '0;
            field_length_reg  <= '0;
            acc_reg           <= '0;
            flags_reg         <= '0;
            traffic_hold_reg  <= '0;
            error_code_reg    <= tilp_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            octet_value_reg   <= octet_value_next;
            octet_digits_reg  <= octet_digits_next;
            octet_index_reg   <= octet_index_next;
            address_shift_reg <= address_shift_next;
            field_length_reg  <= field_length_next;
            acc_reg           <= acc_next;
            flags_reg         <= flags_next;
            traffic_hold_reg  <= traffic_hold_next;
            error_code_reg    <= error_code_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_address_reg <= out_address_next;
        out_traffic_reg <= out_traffic_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign address       = out_address_reg;
    assign traffic_bytes = out_traffic_reg;
    assign record_count  = out_count_reg;

endmodule

`default_nettype wire

/* design/tsv_ipv4_traffic_line_parser.sv */
// Top level of the tab-separated IPv4 traffic line parser.
`default_nettype none

// Parses one text line per result: "a.b.c.d<TAB(s)>megabytes<TAB(s)>count",
// one byte per input transaction, with line_end marking the terminator byte
// (its text_byte is ignored). Each terminator yields exactly one result
// transaction carrying status (0 ok, 1 bad address, 2 missing tab, 3 bad
// traffic number, 4 bad count) plus address, traffic_bytes (megabytes times
// 1048576, wrapped to 64 bits) and record_count; on any error the three data
// fields are zero. A zero byte ends the text early: the rest of the line up
// to the terminator is discarded. Throughput is one byte per clock while
// in_stall is low. The front end classifies each byte and drops text after
// a zero byte; a FIFO_DEPTH-entry queue feeds the back end, which runs the
// parser state machine and one decimal accumulate step per byte. The back
// end retires one byte per cycle; only a terminator waits, and only while
// the result register is full and stalled. With the queue otherwise empty
// and the result register free, a queued terminator loads the result
// register, raising out_valid. in_stall rises only when the queue is full.

module tsv_ipv4_traffic_line_parser #(
    parameter int FIFO_DEPTH = tilp_pkg::FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // byte channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  text_byte,
    input  wire logic        line_end,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      address,
    output logic [63:0]      traffic_bytes,
    output logic [63:0]      record_count
);

    tilp_pkg::fifo_stat_t fifo_stat;
    tilp_pkg::tok_t       push_tok;
    tilp_pkg::tok_t       head;
    logic                 push;
    logic                 pop;

    tilp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .line_end  (line_end),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_tok  (push_tok)
    );

    tilp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    tilp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .fifo_stat     (fifo_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .address       (address),
        .traffic_bytes (traffic_bytes),
        .record_count  (record_count)
    );

endmodule

`default_nettype wire
